/* rtl/ssm_pkg.sv */
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, codes and the character glyph table of the seven-segment
// scroll multiplexer.
// ----------------------------------------------------------------------------
package ssm_pkg;

   // Item kind codes
   localparam logic [2:0] KIND_TICK      = 3'd0;
   localparam logic [2:0] KIND_RAW_WRITE = 3'd1;
   localparam logic [2:0] KIND_CHAR_WRITE = 3'd2;
   localparam logic [2:0] KIND_QUEUE_CHAR = 3'd3;
   localparam logic [2:0] KIND_START     = 3'd4;

   // Blank digit, active low
   localparam logic [7:0] SEG_BLANK = 8'hFF;

   // Scroll delay after reset
   localparam logic [15:0] SCROLL_DELAY_RESET = 16'd200;

   // Request transaction
   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] position;
      logic [7:0] segment_value;
      logic [7:0] character;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [2:0] digit_index;
      logic [7:0] segments;
      logic       scrolling;
      logic       queue_dropped;
   } rsp_type;

   // ASCII to active-low segment pattern; unknown codes are blank
   function automatic logic [7:0] ssm_glyph(input logic [7:0] ch);
      logic [7:0] seg;
      unique case (ch) inside
         8'h30, 8'h4F, 8'h44: seg = 8'hC0; // 0 O D
         8'h31, 8'h49:        seg = 8'hF9; // 1 I
         8'h32, 8'h5A:        seg = 8'hA4; // 2 Z
         8'h33:               seg = 8'hB0;
         8'h34, 8'h59:        seg = 8'h99; // 4 Y
         8'h35, 8'h53:        seg = 8'h92; // 5 S
         8'h36:               seg = 8'h82;
         8'h37:               seg = 8'hF8;
         8'h38, 8'h42:        seg = 8'h80; // 8 B
         8'h39:               seg = 8'h90;
         8'h2D:               seg = 8'hBF; // minus
         8'h41, 8'h52:        seg = 8'h88; // A R
         8'h43:               seg = 8'hC6; // C
         8'h45:               seg = 8'h86; // E
         8'h46:               seg = 8'h8E; // F
         8'h48:               seg = 8'h89; // H
         8'h4C:               seg = 8'hC7; // L
         8'h50:               seg = 8'h8C; // P
         8'h55:               seg = 8'hC1; // U
         8'h54:               seg = 8'hCE; // T
         8'h6F:               seg = 8'hA3; // o
         8'h64:               seg = 8'hA1; // d
         8'h63:               seg = 8'hA7; // c
         default:             seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

endpackage

/* rtl/ssm_ram.sv */
// ----------------------------------------------------------------------------
// ssm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port (read returns old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ssm_queue.sv */
// ----------------------------------------------------------------------------
// ssm_queue
// Scroll character FIFO. The head entry is prefetched from RAM every cycle
// so that it is ready to pop without a read wait.
// ----------------------------------------------------------------------------
module ssm_queue #(
   parameter int DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] push_data,
   input  logic       pop,
   output logic       full,
   output logic       empty,
   output logic [7:0] head_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW:0]   tail_sum;
   logic [AW-1:0] tail;
   logic          fwd_ff, fwd_in;
   logic [7:0]    fwd_data_ff;
   logic [7:0]    ram_rd_data;

   assign full  = (count_ff == DEPTH_C);
   assign empty = (count_ff == '0);

   // Tail address: head plus count, wrapped once
   always_comb begin
      tail_sum = {1'b0, head_ff} + (AW + 1)'(count_ff);
      if (tail_sum >= DEPTH_W) begin
         tail_sum = tail_sum - DEPTH_W;
      end
      tail = tail_sum[AW-1:0];
   end

   // Pointer and count update
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // A write to the entry being prefetched is forwarded
   assign fwd_in = push && (tail == head_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         fwd_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         fwd_ff   <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= push_data;
   end

   ssm_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail),
      .wr_data (push_data),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   assign head_data = fwd_ff ? fwd_data_ff : ram_rd_data;

endmodule

/* rtl/seven_segment_scroll_mux.sv */
// ----------------------------------------------------------------------------
// seven_segment_scroll_mux
// Multiplexed seven-segment display driver with a scrolling text queue.
// ----------------------------------------------------------------------------
// Takes one request transaction per clock while req_stall is low and returns
// one response per request through an input register, then a result
// register. The whole update of a request - scan advance, digit write, start,
// queue append, or a scroll shift with glyph decode of the queue head into
// the last digit - is done in a single pass between those two registers, so
// back-to-back requests sustain one per cycle while rsp_stall is low. The
// scroll queue sits in a RAM whose head entry is prefetched every cycle, so
// a shift never waits on the read. No clearing pass is needed after reset.
// scroll_delay may only be written while no request is in flight.
// ----------------------------------------------------------------------------
module seven_segment_scroll_mux
   import ssm_pkg::*;
#(
   parameter int DIGITS      = 5,
   parameter int QUEUE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int DW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam logic [3:0] DIGITS_N = 4'(DIGITS);
   localparam logic [2:0] LAST_DIGIT = 3'(DIGITS - 1);

   logic          in_valid_ff;
   req_type       in_item_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic          advance, process;

   logic [7:0]    pattern_ff [DIGITS];
   logic [7:0]    pattern_in [DIGITS];
   logic [7:0]    shifted    [DIGITS];
   logic [2:0]    scan_ff, scan_in;
   logic [15:0]   ticks_ff, ticks_in, ticks_inc;
   logic          active_ff, active_in;
   logic [15:0]   delay_ff;
   logic          any_lit;
   logic          do_shift;

   logic          q_push, q_pop, q_full, q_empty;
   logic [7:0]    q_head;

   // Handshake: the pipe moves when the result register is free
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_data;
      end
   end

   // Scroll timing
   assign ticks_inc = ticks_ff + 16'd1;
   assign do_shift  = (in_item_ff.kind == KIND_TICK) && active_ff && (ticks_inc >= delay_ff);

   // Shifted display and blank check, all digits in parallel
   always_comb begin
      any_lit = 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
         shifted[i] = pattern_ff[i];
      end
      for (int i = 0; i < DIGITS - 1; i++) begin
         shifted[i] = pattern_ff[i + 1];
         if (pattern_ff[i + 1] != SEG_BLANK) begin
            any_lit = 1'b1;
         end
      end
      shifted[DIGITS - 1] = q_empty ? SEG_BLANK : ssm_glyph(q_head);
   end

   // Queue controls
   assign q_pop  = process && do_shift && !q_empty;
   assign q_push = process && (in_item_ff.kind == KIND_QUEUE_CHAR) && !q_full;

   // Next state and response
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         pattern_in[i] = pattern_ff[i];
      end
      scan_in     = scan_ff;
      ticks_in    = ticks_ff;
      active_in   = active_ff;
      rsp_data_in = '0;

      unique case (in_item_ff.kind)
         KIND_TICK: begin
            if (active_ff) begin
               ticks_in = ticks_inc;
               if (do_shift) begin
                  ticks_in = '0;
                  for (int i = 0; i < DIGITS; i++) begin
                     pattern_in[i] = shifted[i];
                  end
                  if (q_empty) begin
                     active_in = any_lit;
                  end
               end
            end
            scan_in = (scan_ff == LAST_DIGIT) ? 3'd0 : scan_ff + 3'd1;
         end
         KIND_RAW_WRITE: begin
            if ({1'b0, in_item_ff.position} < DIGITS_N) begin
               pattern_in[in_item_ff.position[DW-1:0]] = ~in_item_ff.segment_value;
            end
         end
         KIND_CHAR_WRITE: begin
            if ({1'b0, in_item_ff.position} < DIGITS_N) begin
               pattern_in[in_item_ff.position[DW-1:0]] = ssm_glyph(in_item_ff.character);
            end
         end
         KIND_QUEUE_CHAR: begin
            rsp_data_in.queue_dropped = q_full;
         end
         KIND_START: begin
            for (int i = 0; i < DIGITS; i++) begin
               pattern_in[i] = SEG_BLANK;
            end
            active_in = 1'b1;
            ticks_in  = '0;
         end
         default: begin
         end
      endcase

      rsp_data_in.digit_index = scan_in;
      rsp_data_in.segments    = pattern_in[scan_in[DW-1:0]];
      rsp_data_in.scrolling   = active_in;
   end

   // Display state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGITS; i++) begin
            pattern_ff[i] <= SEG_BLANK;
         end
         scan_ff   <= '0;
         ticks_ff  <= '0;
         active_ff <= 1'b0;
      end else if (process) begin
         for (int i = 0; i < DIGITS; i++) begin
            pattern_ff[i] <= pattern_in[i];
         end
         scan_ff   <= scan_in;
         ticks_ff  <= ticks_in;
         active_ff <= active_in;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= SCROLL_DELAY_RESET;
      end else if (csr_wr_en) begin
         delay_ff <= csr_wr_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   ssm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (in_item_ff.character),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head_data (q_head)
   );

endmodule

/* sim/seven_segment_scroll_mux_tb.sv */
// ----------------------------------------------------------------------------
// seven_segment_scroll_mux_tb
// Self-checking testbench for the seven-segment scroll multiplexer.
// ----------------------------------------------------------------------------
// Drives request transactions over the valid/stall channel and keeps its own
// model of the display: digit patterns, scan position, scroll timer and the
// character queue. Each response is checked field by field against the
// oldest predicted one. Both channels idle and stall at random. A short
// directed pass is followed by queue overflow, the delay extremes and
// phases of random scroll sequences mixed with noise.
// ----------------------------------------------------------------------------
module seven_segment_scroll_mux_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ssm_pkg::*;

   localparam int DIGITS      = 5;
   localparam int QUEUE_DEPTH = 32;
   localparam int REPORT_MAX  = 40;

   // Kinds with no function: they only report the current state
   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // Display model
   logic [7:0]  pattern_now [DIGITS];
   logic [2:0]  scan_now;
   logic [15:0] tick_count;
   logic        scroll_on;
   logic [7:0]  text_queue [QUEUE_DEPTH];
   logic [4:0]  text_head;
   logic [5:0]  text_count;
   logic [15:0] shift_delay;

   rsp_type     pending_rsp [$];
   int          fail_count  = 0;
   int          items_sent  = 0;
   int          shifts_seen = 0;
   int          drops_seen  = 0;
   int          gap_mode    = 1;
   int          stall_mode  = 1;
   int          stall_run   = 0;
   string       glyph_chars = "0123456789-ABCDEFHILOPRSTUYZodc";

   seven_segment_scroll_mux dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Generous overall limit
   initial begin
      #10_000_000;
      $display("Timeout: responses still outstanding");
      $display("Test completed with failures");
      $finish;
   end

   // ------------------------------------------------------------------
   // Display model
   // ------------------------------------------------------------------
   function automatic logic [7:0] glyph_of(input logic [7:0] ch);
      case (ch)
         "0", "O", "D": return 8'hC0;
         "1", "I":      return 8'hF9;
         "2", "Z":      return 8'hA4;
         "3":           return 8'hB0;
         "4", "Y":      return 8'h99;
         "5", "S":      return 8'h92;
         "6":           return 8'h82;
         "7":           return 8'hF8;
         "8", "B":      return 8'h80;
         "9":           return 8'h90;
         "-":           return 8'hBF;
         "A", "R":      return 8'h88;
         "C":           return 8'hC6;
         "E":           return 8'h86;
         "F":           return 8'h8E;
         "H":           return 8'h89;
         "L":           return 8'hC7;
         "P":           return 8'h8C;
         "U":           return 8'hC1;
         "T":           return 8'hCE;
         "o":           return 8'hA3;
         "d":           return 8'hA1;
         "c":           return 8'hA7;
         default:       return SEG_BLANK;
      endcase
   endfunction

   task automatic reset_display_model();
      for (int i = 0; i < DIGITS; i++) pattern_now[i] = SEG_BLANK;
      scan_now    = '0;
      tick_count  = '0;
      scroll_on   = 1'b0;
      text_head   = '0;
      text_count  = '0;
      shift_delay = SCROLL_DELAY_RESET;
   endtask

   // Shift left; the queue head (or a blank) enters the last digit
   function automatic void shift_digits();
      for (int i = 0; i < DIGITS - 1; i++) pattern_now[i] = pattern_now[i + 1];
      if (text_count != 0) begin
         pattern_now[DIGITS - 1] = glyph_of(text_queue[text_head]);
         text_head  = text_head + 5'd1;
         text_count = text_count - 6'd1;
      end else begin
         pattern_now[DIGITS - 1] = SEG_BLANK;
         scroll_on = 1'b0;
         for (int i = 0; i < DIGITS; i++)
            if (pattern_now[i] != SEG_BLANK) scroll_on = 1'b1;
      end
      shifts_seen++;
   endfunction

   function automatic rsp_type display_step(input req_type it);
      rsp_type    r;
      logic [4:0] tail;
      r = '0;
      case (it.kind)
         KIND_TICK: begin
            if (scroll_on) begin
               tick_count = tick_count + 16'd1;
               if (tick_count >= shift_delay) begin
                  shift_digits();
                  tick_count = '0;
               end
            end
            scan_now = (scan_now == DIGITS - 1) ? 3'd0 : scan_now + 3'd1;
         end
         KIND_RAW_WRITE: begin
            if (it.position < DIGITS) pattern_now[it.position] = ~it.segment_value;
         end
         KIND_CHAR_WRITE: begin
            if (it.position < DIGITS) pattern_now[it.position] = glyph_of(it.character);
         end
         KIND_QUEUE_CHAR: begin
            if (text_count >= QUEUE_DEPTH) begin
               r.queue_dropped = 1'b1;
               drops_seen++;
            end else begin
               tail = text_head + text_count[4:0];
               text_queue[tail] = it.character;
               text_count = text_count + 6'd1;
            end
         end
         KIND_START: begin
            for (int i = 0; i < DIGITS; i++) pattern_now[i] = SEG_BLANK;
            scroll_on  = 1'b1;
            tick_count = '0;
         end
         default: begin
         end
      endcase
      r.digit_index = scan_now;
      r.segments    = pattern_now[scan_now];
      r.scrolling   = scroll_on;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Idling, mismatch reporting and response checking
   // ------------------------------------------------------------------
   // Mostly short pauses, now and then a long one
   function automatic int pick_pause();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   function automatic logic [7:0] pick_char();
      if ($urandom_range(0, 1) == 0)
         return glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (fail_count < REPORT_MAX)
         $display("MISMATCH %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Receiver back-pressure
   always @(posedge clock) begin
      if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run = stall_run - 1;
      end else if (stall_mode != 0 && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_run = pick_pause() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check each accepted response against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with nothing expected", rsp_data, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.digit_index !== want.digit_index)
               report_mismatch("digit_index", rsp_data.digit_index, want.digit_index);
            if (rsp_data.segments !== want.segments)
               report_mismatch("segments", rsp_data.segments, want.segments);
            if (rsp_data.scrolling !== want.scrolling)
               report_mismatch("scrolling", rsp_data.scrolling, want.scrolling);
            if (rsp_data.queue_dropped !== want.queue_dropped)
               report_mismatch("queue_dropped", rsp_data.queue_dropped, want.queue_dropped);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sending, draining and register writes
   // ------------------------------------------------------------------
   task automatic send_item(input logic [2:0] kind, input logic [2:0] position,
                            input logic [7:0] segment_value, input logic [7:0] character);
      req_type it;
      int      gap;
      it.kind          = kind;
      it.position      = position;
      it.segment_value = segment_value;
      it.character     = character;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(display_step(it));
      items_sent++;
      gap = (gap_mode != 0 && $urandom_range(0, 2) == 0) ? pick_pause() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_noise();
      send_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                8'($urandom_range(0, 255)), pick_char());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic set_scroll_delay(input logic [15:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shift_delay  = value;
   endtask

   // Tick until the scroll has run out, with random payload on the ticks
   task automatic run_scroll_out(input int cap);
      while (scroll_on && cap > 0) begin
         send_item(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
         cap--;
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      // scan wraps through every digit
      repeat (DIGITS + 1) send_item(KIND_TICK, 3'd0, 8'h00, 8'h00);
      // raw writes: all segments, none, positions out of range
      send_item(KIND_RAW_WRITE, 3'd0, 8'hFF, 8'h00);
      send_item(KIND_RAW_WRITE, 3'(DIGITS - 1), 8'h00, 8'hFF);
      send_item(KIND_RAW_WRITE, 3'(DIGITS), 8'h5A, 8'hA5);
      send_item(KIND_RAW_WRITE, 3'd7, 8'hA5, 8'h5A);
      // character writes: glyphs, no glyph, code zero, out of range
      send_item(KIND_CHAR_WRITE, 3'd1, 8'h00, "8");
      send_item(KIND_CHAR_WRITE, 3'd2, 8'h00, "c");
      send_item(KIND_CHAR_WRITE, 3'd3, 8'hFF, 8'hFF);
      send_item(KIND_CHAR_WRITE, 3'd4, 8'h00, 8'h00);
      send_item(KIND_CHAR_WRITE, 3'd6, 8'h00, "1");
      // spare kinds change nothing
      send_item(KIND_SPARE_FIRST, 3'd7, 8'hFF, 8'hFF);
      send_item(KIND_SPARE_LAST, 3'd2, 8'h00, "E");
      // queued code zero is an ordinary character; start keeps the queue
      send_item(KIND_QUEUE_CHAR, 3'd0, 8'h00, 8'h00);
      send_item(KIND_QUEUE_CHAR, 3'd7, 8'hFF, "E");
      send_item(KIND_START, 3'd0, 8'h00, 8'h00);
      repeat (DIGITS) send_item(KIND_TICK, 3'd0, 8'h00, 8'h00);
   endtask

   // Shift on every tick; also finishes the scroll left running above
   task automatic test_fast_scroll();
      string word;
      word = "HELLO-2";
      set_scroll_delay(16'd0);
      run_scroll_out(60);
      for (int i = 0; i < word.len(); i++) send_item(KIND_QUEUE_CHAR, 3'd0, 8'h00, word[i]);
      send_item(KIND_START, 3'd0, 8'h00, 8'h00);
      run_scroll_out(60);
      // start with an empty queue ends at the first shift
      send_item(KIND_START, 3'd0, 8'h00, 8'h00);
      run_scroll_out(4);
   endtask

   // Overflow the queue, then drain it with appends during the scroll
   task automatic test_queue_full();
      set_scroll_delay(16'd1);
      repeat (QUEUE_DEPTH - text_count + 3)
         send_item(KIND_QUEUE_CHAR, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                   pick_char());
      // hold off until every response is in
      wait_drained();
      send_item(KIND_START, 3'd0, 8'h00, 8'h00);
      for (int cap = 0; scroll_on && cap < 200; cap++) begin
         if ($urandom_range(0, 7) == 0)
            send_item(KIND_QUEUE_CHAR, 3'd0, 8'h00, pick_char());
         else
            send_item(KIND_TICK, 3'd0, 8'h00, 8'h00);
      end
   endtask

   // Longest delay: the scroll stays put and the timer keeps counting
   task automatic test_long_delay();
      set_scroll_delay(16'hFFFF);
      repeat (3) send_item(KIND_QUEUE_CHAR, 3'd0, 8'h00, pick_char());
      send_item(KIND_START, 3'd0, 8'h00, 8'h00);
      repeat (20) begin
         if ($urandom_range(0, 3) == 0) send_noise();
         else send_item(KIND_TICK, 3'd0, 8'h00, 8'h00);
      end
   endtask

   // Random scroll sequences with random content, plus noise
   task automatic test_random_traffic();
      int target;
      for (int ph = 0; ph < 4; ph++) begin
         set_scroll_delay(ph == 0 ? 16'd3 : 16'($urandom_range(0, 6)));
         gap_mode   = (ph == 1) ? 0 : 1;
         stall_mode = (ph == 1) ? 0 : 1;
         target     = items_sent + 90;
         while (items_sent < target) begin
            if ($urandom_range(0, 14) == 0) wait_drained();
            if ($urandom_range(0, 9) < 6) begin
               repeat ($urandom_range(0, 6))
                  send_item(KIND_QUEUE_CHAR, 3'($urandom_range(0, 7)), 8'h00, pick_char());
               send_item(KIND_START, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
               while (scroll_on && items_sent < target) begin
                  case ($urandom_range(0, 19))
                     0, 1:    send_item(KIND_RAW_WRITE, 3'($urandom_range(0, 7)),
                                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                     2:       send_item(KIND_CHAR_WRITE, 3'($urandom_range(0, 7)),
                                        8'($urandom_range(0, 255)), pick_char());
                     3, 4:    send_item(KIND_QUEUE_CHAR, 3'($urandom_range(0, 7)),
                                        8'($urandom_range(0, 255)), pick_char());
                     default: send_item(KIND_TICK, 3'($urandom_range(0, 7)),
                                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                  endcase
               end
            end else begin
               repeat ($urandom_range(1, 6)) send_noise();
            end
         end
      end
      gap_mode   = 1;
      stall_mode = 1;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset_display_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_fast_scroll();
      test_queue_full();
      test_long_delay();
      test_random_traffic();

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d transactions; model saw %0d scroll shifts and %0d dropped characters",
               items_sent, shifts_seen, drops_seen);
      $display("Scroll delays from 0 to 65535, queue overflow and random idling on both sides");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/ssm_pkg.sv
rtl/ssm_ram.sv
rtl/ssm_queue.sv
rtl/seven_segment_scroll_mux.sv
sim/seven_segment_scroll_mux_tb.sv
